// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define JAOS_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define JAOS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define JAOS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define JAOS_ASSERT(lbl, clk, rstn, expr, msg)
`define JAOS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define JAOS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/jaos_pkg.sv -----
package jaos_pkg;

  localparam int TOKEN_LEN = 10;
  localparam int WIN_DEPTH = TOKEN_LEN - 1;

  localparam logic [7:0] TOKEN [TOKEN_LEN] = '{
    8'h22, 8'h63, 8'h68, 8'h61, 8'h70, 8'h74, 8'h65, 8'h72, 8'h73, 8'h22
  };

  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_QUOTE    = 8'h22;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SEEK   = 2'd1,
    PH_ARRAY  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_OUTSIDE = 2'd0,
    ROLE_OPEN    = 2'd1,
    ROLE_INSIDE  = 2'd2,
    ROLE_CLOSE   = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    FIN_RUNNING  = 3'd0,
    FIN_CLOSED   = 3'd1,
    FIN_BETWEEN  = 3'd2,
    FIN_NO_ARRAY = 3'd3,
    FIN_TRUNC    = 3'd4
  } finish_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      byte_role;
    finish_t    finish;
    logic       depth_overflow;
  } result_t;

endpackage

// ----- hw/rtl/jaos_if.sv -----
interface jaos_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface jaos_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_role;
  logic [2:0] finish;
  logic       depth_overflow;

  modport source (output valid, output out_byte, output byte_role, output finish,
                  output depth_overflow, input ready);
  modport sink (input valid, input out_byte, input byte_role, input finish,
                input depth_overflow, output ready);
endinterface

// ----- hw/rtl/json_array_object_splitter.sv -----
// path: an accepted beat is held in the input register, scanned combinationally, and
// its result is registered in the result register; throughput: one beat per cycle
// while the output is not stalled
// reset: synchronous active-low rst_n clears the scan state, the token window
// and both register valids; the block then searches for the token
`include "assert_macros.svh"

module json_array_object_splitter #(
  parameter int MAX_NEST_DEPTH = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  jaos_in_if.sink           in_beat,
  jaos_out_if.source        out_beat
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              out_valid_r;
  jaos_pkg::result_t out_r;
  jaos_pkg::result_t result;
  jaos_pkg::win_ctl_t win_ctl;
  logic              hit;
  logic              advance;
  logic              step;

  assign advance       = !out_valid_r || out_beat.ready;
  assign step          = in_valid_r && advance;
  assign in_beat.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      in_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      in_byte_r <= in_beat.data_byte;
      in_last_r <= in_beat.is_last;
    end
  end

  jaos_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .data_byte (in_byte_r),
    .hit       (hit)
  );

  jaos_core #(
    .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .is_last   (in_last_r),
    .hit       (hit),
    .win_ctl   (win_ctl),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.out_byte       = out_r.out_byte;
  assign out_beat.byte_role      = out_r.byte_role;
  assign out_beat.finish         = out_r.finish;
  assign out_beat.depth_overflow = out_r.depth_overflow;

  `JAOS_ASSERT_NXT(a_hold_input, clk, rst_n, in_valid_r && !advance, in_valid_r, "pending beat lost")
  `JAOS_ASSERT_NXT(a_step_output, clk, rst_n, step, out_valid_r, "processed beat not presented")

endmodule

// ----- hw/rtl/jaos_window.sv -----
`include "assert_macros.svh"

module jaos_window (
  input  logic              clk,
  input  logic              rst_n,
  input  jaos_pkg::win_ctl_t ctl,
  input  logic [7:0]        data_byte,
  output logic              hit
);

  logic [7:0] win_r [jaos_pkg::WIN_DEPTH];
  logic [3:0] fill_r;
  logic       match;

  always_comb begin
    match = (data_byte == jaos_pkg::TOKEN[jaos_pkg::TOKEN_LEN-1]);
    for (int i = 0; i < jaos_pkg::WIN_DEPTH; i++) begin
      if (win_r[i] != jaos_pkg::TOKEN[i]) begin
        match = 1'b0;
      end
    end
  end

  assign hit = match && (fill_r >= 4'(jaos_pkg::WIN_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      fill_r <= '0;
      for (int i = 0; i < jaos_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < jaos_pkg::WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[jaos_pkg::WIN_DEPTH-1] <= data_byte;
      if (fill_r < 4'(jaos_pkg::WIN_DEPTH)) begin
        fill_r <= fill_r + 4'd1;
      end
    end
  end

  `JAOS_ASSERT(a_fill_bound, clk, rst_n, fill_r <= 4'(jaos_pkg::WIN_DEPTH), "window fill past depth")

endmodule

// ----- hw/rtl/jaos_core.sv -----
`include "assert_macros.svh"

module jaos_core #(
  parameter int MAX_NEST_DEPTH = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                is_last,
  input  logic                hit,
  output jaos_pkg::win_ctl_t  win_ctl,
  output jaos_pkg::result_t   result
);

  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DW-1:0] DepthMax = DW'(MAX_NEST_DEPTH);

  jaos_pkg::phase_t  phase_r, phase_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic              quote_r, quote_nxt;
  logic              bslash_r, bslash_nxt;
  logic              closed;
  jaos_pkg::finish_t fin;
  jaos_pkg::role_t   role;
  logic              ovf;

  // next state and finish code
  always_comb begin
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    quote_nxt  = quote_r;
    bslash_nxt = bslash_r;
    closed     = 1'b0;
    unique case (phase_r)
      jaos_pkg::PH_SEEK: begin
        if (data_byte == jaos_pkg::CH_LBRACKET) begin
          phase_nxt = jaos_pkg::PH_ARRAY;
        end
      end
      jaos_pkg::PH_ARRAY: begin
        if (depth_r == '0) begin
          if (data_byte == jaos_pkg::CH_LBRACE) begin
            depth_nxt  = DW'(1);
            quote_nxt  = 1'b0;
            bslash_nxt = 1'b0;
          end else if (data_byte == jaos_pkg::CH_RBRACKET) begin
            closed = 1'b1;
          end
        end else if (bslash_r) begin
          bslash_nxt = 1'b0;
        end else if (data_byte == jaos_pkg::CH_BSLASH) begin
          bslash_nxt = 1'b1;
        end else if (data_byte == jaos_pkg::CH_QUOTE) begin
          quote_nxt = !quote_r;
        end else if (!quote_r) begin
          if (data_byte == jaos_pkg::CH_LBRACE) begin
            if (depth_r < DepthMax) begin
              depth_nxt = depth_r + DW'(1);
            end
          end else if (data_byte == jaos_pkg::CH_RBRACE) begin
            depth_nxt = depth_r - DW'(1);
          end
        end
      end
      default: begin
        if (hit) begin
          phase_nxt = jaos_pkg::PH_SEEK;
        end
      end
    endcase

    if (closed) begin
      fin = jaos_pkg::FIN_CLOSED;
    end else if (!is_last) begin
      fin = jaos_pkg::FIN_RUNNING;
    end else if (phase_nxt != jaos_pkg::PH_ARRAY) begin
      fin = jaos_pkg::FIN_NO_ARRAY;
    end else if (depth_nxt != '0) begin
      fin = jaos_pkg::FIN_TRUNC;
    end else begin
      fin = jaos_pkg::FIN_BETWEEN;
    end
  end

  // outputs
  always_comb begin
    role = jaos_pkg::ROLE_OUTSIDE;
    ovf  = 1'b0;
    unique case (phase_r)
      jaos_pkg::PH_ARRAY: begin
        if (depth_r == '0) begin
          if (data_byte == jaos_pkg::CH_LBRACE) begin
            role = jaos_pkg::ROLE_OPEN;
          end
        end else begin
          role = jaos_pkg::ROLE_INSIDE;
          if (!bslash_r && !quote_r && data_byte != jaos_pkg::CH_BSLASH
              && data_byte != jaos_pkg::CH_QUOTE) begin
            if (data_byte == jaos_pkg::CH_LBRACE && depth_r >= DepthMax) begin
              ovf = 1'b1;
            end
            if (data_byte == jaos_pkg::CH_RBRACE && depth_r == DW'(1)) begin
              role = jaos_pkg::ROLE_CLOSE;
            end
          end
        end
      end
      default: begin
        role = jaos_pkg::ROLE_OUTSIDE;
      end
    endcase
  end

  assign win_ctl.shift = step && (phase_r != jaos_pkg::PH_SEEK)
                         && (phase_r != jaos_pkg::PH_ARRAY);
  assign win_ctl.clear = step && (fin != jaos_pkg::FIN_RUNNING);

  assign result.out_byte       = data_byte;
  assign result.byte_role      = role;
  assign result.finish         = fin;
  assign result.depth_overflow = ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jaos_pkg::PH_SEARCH;
      depth_r  <= '0;
      quote_r  <= 1'b0;
      bslash_r <= 1'b0;
    end else if (step) begin
      if (fin != jaos_pkg::FIN_RUNNING) begin
        phase_r  <= jaos_pkg::PH_SEARCH;
        depth_r  <= '0;
        quote_r  <= 1'b0;
        bslash_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        depth_r  <= depth_nxt;
        quote_r  <= quote_nxt;
        bslash_r <= bslash_nxt;
      end
    end
  end

  `JAOS_ASSERT(a_depth_bound, clk, rst_n, depth_r <= DepthMax, "brace depth past maximum")
  `JAOS_ASSERT_IMP(a_depth_phase, clk, rst_n, phase_r != jaos_pkg::PH_ARRAY, depth_r == '0, "depth outside array")
  `JAOS_ASSERT_NXT(a_finish_clears, clk, rst_n, step && fin != jaos_pkg::FIN_RUNNING, phase_r == jaos_pkg::PH_SEARCH && depth_r == '0, "finish did not clear state")

endmodule
